[hw/rtl/pld_pkg.sv]
// pld_pkg: shared types, widths and constants for the leaky-integral PID drive
// no dependencies; imported by every module of the block

package pld_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int ERR_W   = POS_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int GAIN_W  = 32;
    localparam int EFF_W   = 32;
    localparam int DRV_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // integral: Q24.17, leak numerator and divide by 20
    localparam int FRAC_I     = 17;
    localparam int INTEG_W    = 42;
    localparam int NUM_W      = 48;
    localparam int LEAK_DIV   = 20;
    localparam int ROUND_HALF = LEAK_DIV / 2;
    localparam int DIV_DIGIT  = 4;
    localparam int DIV_STEPS  = NUM_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int REM_W      = 5;
    localparam int DIVX_W     = REM_W + DIV_DIGIT;
    localparam int DIV_RECIP  = 3277;      // 2^16 / 20 rounded up
    localparam int DIV_SHIFT  = 16;
    localparam int DIVQ_W     = DIVX_W + 12;

    // digit-serial multiplier
    localparam int MUL_DIGIT  = 4;
    localparam int MUL_DATA_W = 44;
    localparam int MUL_STEPS  = MUL_DATA_W / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int PROD_W     = GAIN_W + 1 + MUL_DATA_W;

    // effort and drive
    localparam int Q_W        = 59;
    localparam int Q_FRAC     = 16;
    localparam int Q16_ONE    = 65536;
    localparam int TR_W       = Q_W - Q_FRAC;
    localparam int EFF_MAX    = 2147483647;
    localparam int EFF_MIN    = -2147483647 - 1;
    localparam int V_W        = 64;
    localparam int RQ_W       = V_W - Q_FRAC;
    localparam int ROUND_BIAS = Q16_ONE / 2;
    localparam int DRV_MAX    = 32767;
    localparam int DRV_MIN_MAG = 32768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd7;

    localparam logic signed [GAIN_W-1:0] SCALE_RESET = 32'sd65536;

    typedef struct packed {
        logic signed [POS_W-1:0] setpoint;
        logic signed [POS_W-1:0] position;
        logic                    restart;
    } t_in_word;

    typedef struct packed {
        logic signed [EFF_W-1:0] control_effort;
        logic signed [DRV_W-1:0] drive;
    } t_out_word;

endpackage

[hw/rtl/pld_smul.sv]
// pld_smul: signed multiplier, gain times data, four data bits per cycle
// depends on pld_pkg for widths and step count

module pld_smul import pld_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [GAIN_W-1:0] i_gain,
    input  logic signed [MUL_DATA_W-1:0] i_data,
    output logic                     o_busy,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_prod
);

    logic                          r_busy;
    logic                          r_done;
    logic [MUL_CNT_W-1:0]          r_cnt;
    logic signed [GAIN_W-1:0]      r_gain;
    logic signed [GAIN_W:0]        r_hi;
    logic [MUL_DATA_W-1:0]         r_lo;

    logic                          w_last;
    logic signed [MUL_DIGIT:0]     w_digit;
    logic signed [GAIN_W+MUL_DIGIT:0] w_term;
    logic signed [GAIN_W+MUL_DIGIT:0] w_sum;

    // top digit of the data carries the sign
    assign w_last  = (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));
    assign w_digit = {w_last & r_lo[MUL_DIGIT-1], r_lo[MUL_DIGIT-1:0]};
    assign w_term  = r_gain * w_digit;
    assign w_sum   = (GAIN_W + MUL_DIGIT + 1)'(r_hi) + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_gain <= i_gain;
                r_hi   <= '0;
                r_lo   <= i_data;
            end else if (r_busy) begin
                r_hi  <= w_sum[GAIN_W+MUL_DIGIT:MUL_DIGIT];
                r_lo  <= {w_sum[MUL_DIGIT-1:0], r_lo[MUL_DATA_W-1:MUL_DIGIT]};
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

[hw/rtl/pld_div20.sv]
// pld_div20: leak divide, signed numerator over 20 rounded half away from zero
// one 4-bit quotient digit per cycle; depends on pld_pkg

module pld_div20 import pld_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [NUM_W-1:0]   i_num,
    output logic                      o_busy,
    output logic                      o_done,
    output logic signed [INTEG_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [NUM_W-1:0]     r_dvd;
    logic [REM_W-1:0]     r_rem;

    logic [DIVX_W-1:0]    w_x;
    logic [DIVQ_W-1:0]    w_qx;
    logic [DIV_DIGIT-1:0] w_qd;
    logic [DIVX_W-1:0]    w_q20;
    logic [DIVX_W-1:0]    w_rem_full;
    logic [INTEG_W-1:0]   w_mag;

    // partial remainder stays below 20, so x < 320 and the reciprocal is exact
    assign w_x        = {r_rem, r_dvd[NUM_W-1 -: DIV_DIGIT]};
    assign w_qx       = DIVQ_W'(w_x) * DIVQ_W'(DIV_RECIP);
    assign w_qd       = w_qx[DIV_SHIFT +: DIV_DIGIT];
    assign w_q20      = DIVX_W'(w_qd) * DIVX_W'(LEAK_DIV);
    assign w_rem_full = w_x - w_q20;
    assign w_mag      = r_dvd[INTEG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_neg  <= i_num[NUM_W-1];
                // magnitude plus half the divisor
                r_dvd  <= i_num[NUM_W-1] ? (~i_num + NUM_W'(ROUND_HALF + 1))
                                         : (i_num + NUM_W'(ROUND_HALF));
            end else if (r_busy) begin
                r_rem <= w_rem_full[REM_W-1:0];
                r_dvd <= {r_dvd[NUM_W-DIV_DIGIT-1:0], w_qd};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? -w_mag : w_mag;

endmodule

[hw/rtl/pid_leaky_integral_drive_top.sv]
// A tick of the PID drive runs through digit-serial units working four bits per
// cycle: the leak divide by 20 (12 digits), then three parallel multiplier lanes
// for kp*e, kd*d and ki*I (11 digits), then lane 0 again for effort*output_scale,
// followed by steps for the sum, polarity, truncation, offset, deadband, rounding
// and saturation; a restart tick goes straight to the output scaling. A finished
// word sits in the output register while the next tick is accepted. Configuration
// writes take effect at once and should be made only while no tick is in flight.
// pid_leaky_integral_drive_top: control sequencer, state, config registers
// depends on pld_pkg, pld_div20 and pld_smul

module pid_leaky_integral_drive_top import pld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_LEAK, S_DIV, S_PID, S_MUL, S_SUM, S_POL, S_EFF,
        S_SCL, S_SCW, S_OFS, S_DB, S_RND, S_SAT, S_DONE
    } t_state;

    t_state                     r_state;

    logic signed [GAIN_W-1:0]   r_kp, r_ki, r_kd, r_scale;
    logic                       r_pol;
    logic signed [DRV_W-1:0]    r_stop, r_upper, r_lower;

    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_last_err;

    logic signed [ERR_W-1:0]    r_err;
    logic signed [Q_W-1:0]      r_q;
    logic signed [EFF_W-1:0]    r_effort;
    logic signed [V_W-1:0]      r_v;
    logic                       r_neg_v;
    logic [V_W-1:0]             r_mag;
    logic signed [DRV_W-1:0]    r_drive;

    logic                       r_out_valid;
    t_out_word                  r_out_word;

    logic                       w_in_acc;
    logic                       w_out_acc;
    logic signed [NUM_W-1:0]    w_num;
    logic                       w_div_start, w_div_busy, w_div_done;
    logic signed [INTEG_W-1:0]  w_quot;
    logic                       w_flip;
    logic signed [INTEG_W-1:0]  w_integ_new;
    logic signed [DIFF_W-1:0]   w_diff;

    logic                       w_start [3];
    logic signed [GAIN_W-1:0]   w_gain [3];
    logic signed [MUL_DATA_W-1:0] w_data [3];
    logic                       w_mul_busy [3];
    logic                       w_mul_done [3];
    logic signed [PROD_W-1:0]   w_prod [3];

    logic [Q_W-1:0]             w_qsum;
    logic signed [Q_W-1:0]      w_biased;
    logic signed [TR_W-1:0]     w_trunc;
    logic signed [V_W-1:0]      w_stop_q, w_up_q, w_lo_q;
    logic [RQ_W-1:0]            w_rq;
    logic signed [DRV_W-1:0]    w_drv;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // leak numerator e*2^17 + 19*I, with 19 = 16 + 2 + 1
    assign w_num = (NUM_W'(r_err) <<< FRAC_I) + (NUM_W'(r_integ) <<< 4)
                 + (NUM_W'(r_integ) <<< 1) + NUM_W'(r_integ);

    assign w_div_start = (r_state == S_LEAK);

    pld_div20 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // integral drops to zero when the error crosses zero
    assign w_flip      = r_last_err[ERR_W-1] != r_err[ERR_W-1];
    assign w_integ_new = w_flip ? '0 : w_quot;
    assign w_diff      = DIFF_W'(r_err) - DIFF_W'(r_last_err);

    // lane 0 doubles as the output scaler
    assign w_start[0] = (r_state == S_PID) || (r_state == S_SCL);
    assign w_start[1] = (r_state == S_PID);
    assign w_start[2] = (r_state == S_PID);
    assign w_gain[0]  = (r_state == S_SCL) ? r_scale : r_kp;
    assign w_gain[1]  = r_kd;
    assign w_gain[2]  = r_ki;
    assign w_data[0]  = (r_state == S_SCL) ? MUL_DATA_W'(r_effort) : MUL_DATA_W'(r_err);
    assign w_data[1]  = MUL_DATA_W'(w_diff);
    assign w_data[2]  = MUL_DATA_W'(w_integ_new);

    for (genvar g = 0; g < 3; g++) begin : g_lane
        pld_smul u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start[g]),
            .i_gain  (w_gain[g]),
            .i_data  (w_data[g]),
            .o_busy  (w_mul_busy[g]),
            .o_done  (w_mul_done[g]),
            .o_prod  (w_prod[g])
        );
    end

    // ki*I is Q.33, floor to Q.16 by arithmetic shift
    assign w_qsum = w_prod[0][Q_W-1:0] + w_prod[1][Q_W-1:0]
                  + w_prod[2][Q_W+FRAC_I-1:FRAC_I];

    // truncate toward zero: bias negatives before the shift
    assign w_biased = r_q + (r_q[Q_W-1] ? Q_W'(Q16_ONE - 1) : Q_W'(0));
    assign w_trunc  = w_biased[Q_W-1:Q_FRAC];

    assign w_stop_q = V_W'(r_stop) <<< Q_FRAC;
    assign w_up_q   = V_W'(r_upper) <<< Q_FRAC;
    assign w_lo_q   = V_W'(r_lower) <<< Q_FRAC;

    assign w_rq = r_mag[V_W-1:Q_FRAC];

    always_comb begin
        if (r_neg_v) begin
            if (w_rq > RQ_W'(DRV_MIN_MAG)) begin
                w_drv = DRV_W'(-DRV_MIN_MAG);
            end else begin
                w_drv = -w_rq[DRV_W-1:0];
            end
        end else begin
            if (w_rq > RQ_W'(DRV_MAX)) begin
                w_drv = DRV_W'(DRV_MAX);
            end else begin
                w_drv = w_rq[DRV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_pol       <= 1'b1;
            r_scale     <= SCALE_RESET;
            r_stop      <= '0;
            r_upper     <= '0;
            r_lower     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_KI:    r_ki    <= i_cfg_data;
                    CFG_KD:    r_kd    <= i_cfg_data;
                    CFG_POL:   r_pol   <= i_cfg_data[0];
                    CFG_SCALE: r_scale <= i_cfg_data;
                    CFG_STOP:  r_stop  <= i_cfg_data[DRV_W-1:0];
                    CFG_UPPER: r_upper <= i_cfg_data[DRV_W-1:0];
                    CFG_LOWER: r_lower <= i_cfg_data[DRV_W-1:0];
                    default: ;
                endcase
            end

            // in S_DONE the valid flag is handled by the load below
            if (w_out_acc && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_err <= ERR_W'(i_in_word.setpoint) - ERR_W'(i_in_word.position);
                        if (i_in_word.restart) begin
                            r_integ    <= '0;
                            r_last_err <= '0;
                            r_effort   <= '0;
                            r_state    <= S_SCL;
                        end else begin
                            r_state <= S_LEAK;
                        end
                    end
                end
                S_LEAK: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_PID;
                    end
                end
                S_PID: begin
                    r_integ    <= w_integ_new;
                    r_last_err <= r_err;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done[0] && w_mul_done[1] && w_mul_done[2]) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_q     <= w_qsum;
                    r_state <= S_POL;
                end
                S_POL: begin
                    if (!r_pol) begin
                        r_q <= -r_q;
                    end
                    r_state <= S_EFF;
                end
                S_EFF: begin
                    if (w_trunc > TR_W'(EFF_MAX)) begin
                        r_effort <= EFF_W'(EFF_MAX);
                    end else if (w_trunc < TR_W'(EFF_MIN)) begin
                        r_effort <= EFF_W'(EFF_MIN);
                    end else begin
                        r_effort <= w_trunc[EFF_W-1:0];
                    end
                    r_state <= S_SCL;
                end
                S_SCL: r_state <= S_SCW;
                S_SCW: begin
                    if (w_mul_done[0]) begin
                        r_state <= S_OFS;
                    end
                end
                S_OFS: begin
                    r_v     <= w_prod[0][V_W-1:0] + w_stop_q;
                    r_state <= S_DB;
                end
                S_DB: begin
                    // push small drives out of the deadband around stop
                    if (r_v > w_stop_q && r_v < w_up_q) begin
                        r_v <= w_up_q;
                    end else if (r_v < w_stop_q && r_v > w_lo_q) begin
                        r_v <= w_lo_q;
                    end
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_neg_v <= r_v[V_W-1];
                    r_mag   <= r_v[V_W-1] ? (~r_v + V_W'(ROUND_BIAS + 1))
                                          : (r_v + V_W'(ROUND_BIAS));
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_drive <= w_drv;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.control_effort  <= r_effort;
                        r_out_word.drive           <= r_drive;
                        r_state                    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_word.restart |=> (r_integ == '0) && (r_last_err == '0))
        else $error("restart did not clear integral state");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_busy && (w_mul_busy[0] || w_mul_busy[1] || w_mul_busy[2])))
        else $error("divider and multipliers overlap");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && i_out_stall |=> $stable(r_out_word))
        else $error("pending output word overwritten");

endmodule
